@@ rtl/core/bba_pkg.sv @@
// Shared constants, codes and types of the bitmap block allocator.
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
	localparam int ADDR_W     = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int BLK_W      = 12;
	localparam int CNT_W      = 13;
	localparam int STAT_W     = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4096);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_MOD  = 3'b100
	} state_t;

endpackage

@@ rtl/core/bba_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/bitmap_block_allocator_core.sv @@
// Top level of the first-fit bitmap block allocator.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  config   | cfg_valid / cfg_ready     | cfg_data (total_blocks)
//  request  | start & !busy             | operation, block_number
//  result   | done, one cycle strobe    | allocated_block, status
//
// Each item passes three steps: accept, summary search and bitmap read, then
// lowest-free encode and write back; done follows and a new item may be
// accepted in that same cycle. The bitmap sits in a 64 x 64 RAM; per-word
// valid flags and a full-word summary in flops, cleared by arst_n, so the
// bitmap reads as all free after reset with no clearing pass.
// The result side cannot stall; busy is the only back-pressure on requests.
module bitmap_block_allocator_core
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [BLK_W-1:0]  block_number,
	output logic              done,
	output logic [BLK_W-1:0]  allocated_block,
	output logic [STAT_W-1:0] status
);

	state_t state_q;
	logic [CNT_W-1:0] total_q;
	logic [MAP_WORDS-1:0] valid_q;
	logic [MAP_WORDS-1:0] full_q;
	logic op_q;
	logic [BLK_W-1:0] blk_q;
	logic [ADDR_W-1:0] addr_s1;
	logic none_s1;
	logic done_q;
	logic [BLK_W-1:0] result_q;
	logic [STAT_W-1:0] status_q;

	logic [CNT_W-1:0] limit;
	logic [ADDR_W-1:0] first_open;
	logic any_open;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] word;
	logic [BIT_W-1:0] free_bit;
	logic any_free;
	logic [BLK_W-1:0] cand;
	logic [BLK_W-1:0] blk_n;
	logic [WORD_BITS-1:0] wdata;
	logic we;
	logic [BLK_W-1:0] res_d;
	logic [STAT_W-1:0] stat_d;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign allocated_block = result_q;
	assign status = status_q;

	assign limit = (total_q > COUNT_MAX) ? COUNT_MAX : total_q;

	// lowest word that still has a free block
	always_comb begin
		first_open = '0;
		any_open = 1'b0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				first_open = ADDR_W'(i);
				any_open = 1'b1;
			end
		end
	end

	assign rd_addr = (op_q == OP_ALLOC) ? first_open : blk_q[BLK_W-1:BIT_W];

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk(clk),
		.we(we),
		.waddr(addr_s1),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign word = valid_q[addr_s1] ? rdata : '0;

	// lowest clear bit of the word
	always_comb begin
		free_bit = '0;
		any_free = 1'b0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				free_bit = BIT_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign cand = {addr_s1, free_bit};
	assign blk_n = blk_q;

	always_comb begin
		we = 1'b0;
		wdata = word;
		res_d = '0;
		stat_d = STAT_OK;
		if (op_q == OP_ALLOC) begin
			if (none_s1 || !any_free || ({1'b0, cand} >= limit)) begin
				stat_d = STAT_FULL;
			end else begin
				we = (state_q == ST_MOD);
				wdata = word | (WORD_BITS'(1) << free_bit);
				res_d = cand;
			end
		end else begin
			if ({1'b0, blk_n} >= limit) begin
				stat_d = STAT_RANGE;
			end else begin
				we = (state_q == ST_MOD);
				wdata = word & ~(WORD_BITS'(1) << blk_n[BIT_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= COUNT_RESET;
			valid_q <= '0;
			full_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MOD);
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
					if (we) begin
						valid_q[addr_s1] <= 1'b1;
						full_q[addr_s1] <= &wdata;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= operation;
			blk_q <= block_number;
		end
		if (state_q == ST_READ) begin
			addr_s1 <= rd_addr;
			none_s1 <= !any_open;
		end
		if (state_q == ST_MOD) begin
			result_q <= res_d;
			status_q <= stat_d;
		end
	end

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |=> done_q)
		else $error("result strobe missing after write-back cycle");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_READ))
		else $error("accepted item did not start a bitmap read");

	a_we_mod: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_MOD))
		else $error("bitmap write outside write-back cycle");

	a_zero_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != STAT_OK) |-> (result_q == '0))
		else $error("non-zero block number on failed item");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while an item is in flight");

endmodule
